### sv/owcs_pkg.sv
// Shared types, widths and helpers for the overlay window clip unit.
// No dependencies.
`default_nettype none
package owcs_pkg;

   localparam int SIZE_W = 15;            // unsigned size and source corner fields
   localparam int POS_W  = 16;            // signed positions and result fields
   localparam int PROD_W = 2 * SIZE_W;    // size * margin product
   localparam int WORK_W = 18;            // signed working width of the final sums
   localparam int QUOT_W = SIZE_W;        // share never exceeds the source size
   localparam int DIV_LAT = QUOT_W + 1;   // multiply stage plus one stage per quotient bit

   localparam logic [SIZE_W-1:0] SCREEN_W_RESET = 15'd1920;
   localparam logic [SIZE_W-1:0] SCREEN_H_RESET = 15'd1080;

   // left share is forced even
   localparam logic [QUOT_W-1:0] EVEN_MASK = ~(QUOT_W'(1));

   typedef enum logic {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } reg_index_type;

   // word carried down the pipeline alongside the share dividers
   typedef struct packed {
      logic              vis;
      logic [SIZE_W-1:0] sx;
      logic [SIZE_W-1:0] sy;
      logic [SIZE_W-1:0] sw;
      logic [SIZE_W-1:0] sh;
      logic [POS_W-1:0]  dx;
      logic [POS_W-1:0]  dy;
      logic [SIZE_W-1:0] dw;
      logic [SIZE_W-1:0] dh;
      logic [POS_W-1:0]  dxf;
      logic [POS_W-1:0]  dyf;
      logic [SIZE_W-1:0] dwf;
      logic [SIZE_W-1:0] dhf;
      logic [SIZE_W-1:0] ml;
      logic [SIZE_W-1:0] mt;
      logic [SIZE_W-1:0] mr;
      logic [SIZE_W-1:0] mb;
   } front_type;

   // wrap to cb bits two's complement, then present as a 16 bit field
   function automatic logic [POS_W-1:0] coord_wrap(input logic [WORK_W-1:0] v,
                                                   input int unsigned cb);
      logic [31:0]      e;
      logic [POS_W-1:0] r;
      e = 32'(signed'(v));
      for (int i = 0; i < POS_W; i++) begin
         r[i] = (i < cb) ? e[i] : e[cb-1];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/owcs_front.sv
// Front stage: off screen test, clipped destination and the four margins.
// Uses owcs_pkg.
`default_nettype none
module owcs_front import owcs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [SIZE_W-1:0] source_x,
   input  wire logic [SIZE_W-1:0] source_y,
   input  wire logic [SIZE_W-1:0] source_width,
   input  wire logic [SIZE_W-1:0] source_height,
   input  wire logic [POS_W-1:0]  dest_x,
   input  wire logic [POS_W-1:0]  dest_y,
   input  wire logic [SIZE_W-1:0] dest_width,
   input  wire logic [SIZE_W-1:0] dest_height,
   input  wire logic [SIZE_W-1:0] screen_w,
   input  wire logic [SIZE_W-1:0] screen_h,
   output front_type              front_ff
);

   front_type front_in;

   always_comb begin
      logic signed [WORK_W-1:0] dxs, dys, dws, dhs, vws, vhs;
      logic signed [WORK_W-1:0] dw1, dh1, dx1, dy1, ex, ey, mrs, mbs;
      logic                     invis, cl, ct;
      dxs = WORK_W'(signed'(dest_x));
      dys = WORK_W'(signed'(dest_y));
      dws = WORK_W'(dest_width);
      dhs = WORK_W'(dest_height);
      vws = WORK_W'(screen_w);
      vhs = WORK_W'(screen_h);
      invis = (dxs < -dws) || (dys < -dhs) || (dxs > vws) || (dys > vhs);
      cl  = dxs < 0;
      ct  = dys < 0;
      dw1 = cl ? dws + dxs : dws;
      dh1 = ct ? dhs + dys : dhs;
      dx1 = cl ? '0 : dxs;
      dy1 = ct ? '0 : dys;
      ex  = dx1 + dw1 - vws;
      ey  = dy1 + dh1 - vhs;
      mrs = (ex > 0) ? ex : '0;
      mbs = (ey > 0) ? ey : '0;

      front_in.vis = !invis;
      front_in.sx  = source_x;
      front_in.sy  = source_y;
      front_in.sw  = source_width;
      front_in.sh  = source_height;
      front_in.dx  = dest_x;
      front_in.dy  = dest_y;
      front_in.dw  = dest_width;
      front_in.dh  = dest_height;
      front_in.dxf = POS_W'(dx1);
      front_in.dyf = POS_W'(dy1);
      front_in.dwf = SIZE_W'(dw1 - mrs);
      front_in.dhf = SIZE_W'(dh1 - mbs);
      // zero margin gives a zero share
      front_in.ml  = (!invis && cl) ? SIZE_W'(-dxs) : '0;
      front_in.mt  = (!invis && ct) ? SIZE_W'(-dys) : '0;
      front_in.mr  = invis ? '0 : SIZE_W'(mrs);
      front_in.mb  = invis ? '0 : SIZE_W'(mbs);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         front_ff <= front_in;
      end
   end

endmodule
`default_nettype wire

### sv/owcs_scale.sv
// Pipelined share unit: trunc(size * margin / whole), one multiply stage then
// one restoring divide stage per quotient bit. Uses owcs_pkg.
`default_nettype none
module owcs_scale import owcs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [SIZE_W-1:0] size,
   input  wire logic [SIZE_W-1:0] margin,
   input  wire logic [SIZE_W-1:0] whole,
   output logic      [QUOT_W-1:0] quot
);

   logic [PROD_W-1:0] rem_ff [0:QUOT_W-1];
   logic [PROD_W-1:0] rem_in [1:QUOT_W-1];
   logic [SIZE_W-1:0] den_ff [0:QUOT_W-1];
   logic [QUOT_W-1:0] q_ff   [0:QUOT_W];
   logic [QUOT_W-1:0] q_in   [1:QUOT_W];

   always_comb begin
      logic [PROD_W-1:0] shd;
      logic              ge;
      for (int j = 1; j < QUOT_W; j++) begin
         shd = PROD_W'(den_ff[j-1]) << (QUOT_W - j);
         ge  = rem_ff[j-1] >= shd;
         rem_in[j] = ge ? rem_ff[j-1] - shd : rem_ff[j-1];
         q_in[j]   = {q_ff[j-1][QUOT_W-2:0], ge};
      end
      // last bit: only the quotient is kept
      shd = PROD_W'(den_ff[QUOT_W-1]);
      ge  = rem_ff[QUOT_W-1] >= shd;
      q_in[QUOT_W] = {q_ff[QUOT_W-1][QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= PROD_W'(size) * PROD_W'(margin);
         den_ff[0] <= (whole == '0) ? SIZE_W'(1) : whole;   // guard, margin is 0 there
         q_ff[0]   <= '0;
         for (int j = 1; j <= QUOT_W; j++) begin
            q_ff[j] <= q_in[j];
            if (j < QUOT_W) begin
               rem_ff[j] <= rem_in[j];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign quot = q_ff[QUOT_W];

endmodule
`default_nettype wire

### sv/overlay_window_clip_scaled_unit.sv
// Top level of the overlay window clip unit: register port, pipeline control,
// result assembly. Uses owcs_pkg, owcs_front, owcs_scale.
//
// Clips an overlay's screen destination rectangle to the visible screen
// (screen_width x screen_height, set through the register port) and trims the
// source rectangle by the same share, so the scale factor is kept. A word that
// lies wholly off screen comes back with visible low and every field passed
// through. The unit takes one word every cycle unless the output stalls: the
// front stage takes the word at acceptance, then come sixteen stages of the
// share dividers (one multiply plus one stage per quotient bit) and the output
// register. The whole pipeline moves as one: it advances whenever the output
// register is empty or being taken, so req_ready falls only while a result
// waits on rsp_ready. Registers: 0x0 screen_width, 0x4 screen_height, 15 bits
// each, read back as written; write them only while the unit is empty.
`default_nettype none
module overlay_window_clip_scaled_unit import owcs_pkg::*; #(
   parameter int unsigned COORD_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic        [SIZE_W-1:0] req_source_x,
   input  wire logic        [SIZE_W-1:0] req_source_y,
   input  wire logic        [SIZE_W-1:0] req_source_width,
   input  wire logic        [SIZE_W-1:0] req_source_height,
   input  wire logic signed [POS_W-1:0]  req_dest_x,
   input  wire logic signed [POS_W-1:0]  req_dest_y,
   input  wire logic        [SIZE_W-1:0] req_dest_width,
   input  wire logic        [SIZE_W-1:0] req_dest_height,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_visible,
   output logic signed [POS_W-1:0]      rsp_clipped_source_x,
   output logic signed [POS_W-1:0]      rsp_clipped_source_y,
   output logic signed [POS_W-1:0]      rsp_clipped_source_width,
   output logic signed [POS_W-1:0]      rsp_clipped_source_height,
   output logic signed [POS_W-1:0]      rsp_clipped_dest_x,
   output logic signed [POS_W-1:0]      rsp_clipped_dest_y,
   output logic signed [POS_W-1:0]      rsp_clipped_dest_width,
   output logic signed [POS_W-1:0]      rsp_clipped_dest_height,
   // register port
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [2:0]              csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic      [31:0]             csr_prdata,
   output logic                         csr_pready
);

   // ---- registers --------------------------------------------------------
   logic [SIZE_W-1:0] screen_w_ff, screen_h_ff;
   logic              csr_wr;
   reg_index_type     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[2]);   // byte lanes ignored

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff <= SCREEN_W_RESET;
         screen_h_ff <= SCREEN_H_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SCREEN_WIDTH:  screen_w_ff <= csr_pwdata[SIZE_W-1:0];
            REG_SCREEN_HEIGHT: screen_h_ff <= csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SCREEN_WIDTH:  csr_prdata = 32'(screen_w_ff);
         REG_SCREEN_HEIGHT: csr_prdata = 32'(screen_h_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---- pipeline control -------------------------------------------------
   // One enable for every stage; valid bits ride along so bubbles are harmless.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic front_v_ff;
   logic pipe_v_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            pipe_v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         front_v_ff   <= req_valid;
         pipe_v_ff[0] <= front_v_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            pipe_v_ff[i] <= pipe_v_ff[i-1];
         end
      end
   end

   // ---- front stage ------------------------------------------------------
   front_type front_ff;

   owcs_front u_front (
      .clock         (clock),
      .enable        (adv),
      .source_x      (req_source_x),
      .source_y      (req_source_y),
      .source_width  (req_source_width),
      .source_height (req_source_height),
      .dest_x        (req_dest_x),
      .dest_y        (req_dest_y),
      .dest_width    (req_dest_width),
      .dest_height   (req_dest_height),
      .screen_w      (screen_w_ff),
      .screen_h      (screen_h_ff),
      .front_ff      (front_ff)
   );

   // ---- share dividers, one lane per edge --------------------------------
   logic [QUOT_W-1:0] q_left, q_top, q_right, q_bottom;

   owcs_scale u_left (
      .clock (clock), .enable (adv),
      .size (front_ff.sw), .margin (front_ff.ml), .whole (front_ff.dw), .quot (q_left)
   );
   owcs_scale u_top (
      .clock (clock), .enable (adv),
      .size (front_ff.sh), .margin (front_ff.mt), .whole (front_ff.dh), .quot (q_top)
   );
   owcs_scale u_right (
      .clock (clock), .enable (adv),
      .size (front_ff.sw), .margin (front_ff.mr), .whole (front_ff.dw), .quot (q_right)
   );
   // bottom trim on the vertical ratio
   owcs_scale u_bottom (
      .clock (clock), .enable (adv),
      .size (front_ff.sh), .margin (front_ff.mb), .whole (front_ff.dh), .quot (q_bottom)
   );

   // word delay line, aligned with the divider outputs
   front_type pay_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         pay_ff[0] <= front_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            pay_ff[i] <= pay_ff[i-1];
         end
      end
   end

   // ---- result assembly --------------------------------------------------
   front_type         p;
   logic [QUOT_W-1:0] off_l;
   logic [WORK_W-1:0] sx_w, sy_w, sw_w, sh_w, dx_w, dy_w, dw_w, dh_w;

   assign p     = pay_ff[DIV_LAT-1];
   assign off_l = q_left & EVEN_MASK;

   always_comb begin
      if (p.vis) begin
         sx_w = WORK_W'(p.sx) + WORK_W'(off_l);
         sy_w = WORK_W'(p.sy) + WORK_W'(q_top);
         sw_w = WORK_W'(p.sw) - WORK_W'(off_l) - WORK_W'(q_right);
         sh_w = WORK_W'(p.sh) - WORK_W'(q_top) - WORK_W'(q_bottom);
         dx_w = WORK_W'(signed'(p.dxf));
         dy_w = WORK_W'(signed'(p.dyf));
         dw_w = WORK_W'(p.dwf);
         dh_w = WORK_W'(p.dhf);
      end else begin
         // off screen: everything passes through
         sx_w = WORK_W'(p.sx);
         sy_w = WORK_W'(p.sy);
         sw_w = WORK_W'(p.sw);
         sh_w = WORK_W'(p.sh);
         dx_w = WORK_W'(signed'(p.dx));
         dy_w = WORK_W'(signed'(p.dy));
         dw_w = WORK_W'(p.dw);
         dh_w = WORK_W'(p.dh);
      end
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pipe_v_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_visible               <= p.vis;
         rsp_clipped_source_x      <= coord_wrap(sx_w, COORD_BITS);
         rsp_clipped_source_y      <= coord_wrap(sy_w, COORD_BITS);
         rsp_clipped_source_width  <= coord_wrap(sw_w, COORD_BITS);
         rsp_clipped_source_height <= coord_wrap(sh_w, COORD_BITS);
         rsp_clipped_dest_x        <= coord_wrap(dx_w, COORD_BITS);
         rsp_clipped_dest_y        <= coord_wrap(dy_w, COORD_BITS);
         rsp_clipped_dest_width    <= coord_wrap(dw_w, COORD_BITS);
         rsp_clipped_dest_height   <= coord_wrap(dh_w, COORD_BITS);
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### sv/owcs_check.sv
// Port-level checker for overlay_window_clip_scaled_unit, with its bind.
// Uses owcs_pkg.
`default_nettype none
module owcs_check import owcs_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_visible,
   input wire logic [POS_W-1:0]  rsp_clipped_source_x,
   input wire logic [POS_W-1:0]  rsp_clipped_dest_width
);

   // held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // held result keeps its word
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_visible) && $stable(rsp_clipped_source_x)
                                  && $stable(rsp_clipped_dest_width))
      else $error("result word changed while stalled");

   // intake is never blocked while the output side is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled with output free");

   // no result is offered right after a reset cycle
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind overlay_window_clip_scaled_unit owcs_check u_owcs_check (
   .clock                  (clock),
   .reset                  (reset),
   .req_ready              (req_ready),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_visible            (rsp_visible),
   .rsp_clipped_source_x   (rsp_clipped_source_x),
   .rsp_clipped_dest_width (rsp_clipped_dest_width)
);
`default_nettype wire

### tb/overlay_window_clip_scaled_unit_tb.sv
// Testbench for the overlay window clip unit: drives rectangles, predicts the
// clipped result of each and checks it. Depends on owcs_pkg and the unit RTL.
`timescale 1ns / 1ps
module overlay_window_clip_scaled_unit_tb;
   import owcs_pkg::*;

   // one rectangle word as presented on the request channel
   typedef struct {
      logic [SIZE_W-1:0] sx, sy, sw, sh;
      logic [POS_W-1:0]  dx, dy;
      logic [SIZE_W-1:0] dw, dh;
   } rect_type;

   // one clipped result as seen on the result channel
   typedef struct {
      logic             vis;
      logic [POS_W-1:0] sx, sy, sw, sh, dx, dy, dw, dh;
   } clip_type;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   wire  req_ready;
   logic [SIZE_W-1:0] req_source_x = '0, req_source_y = '0;
   logic [SIZE_W-1:0] req_source_width = 15'd1, req_source_height = 15'd1;
   logic signed [POS_W-1:0] req_dest_x = '0, req_dest_y = '0;
   logic [SIZE_W-1:0] req_dest_width = 15'd1, req_dest_height = 15'd1;

   wire rsp_valid;
   logic rsp_ready = 1'b0;
   wire rsp_visible;
   wire signed [POS_W-1:0] rsp_clipped_source_x, rsp_clipped_source_y;
   wire signed [POS_W-1:0] rsp_clipped_source_width, rsp_clipped_source_height;
   wire signed [POS_W-1:0] rsp_clipped_dest_x, rsp_clipped_dest_y;
   wire signed [POS_W-1:0] rsp_clipped_dest_width, rsp_clipped_dest_height;

   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire [31:0] csr_prdata;
   wire csr_pready;

   overlay_window_clip_scaled_unit #(.COORD_BITS(16)) DUT (.*);

   always #4 clock = ~clock;

   // predictor's copy of the screen size registers, signed so that
   // comparisons with negative positions stay signed
   longint scr_w = longint'(SCREEN_W_RESET);
   longint scr_h = longint'(SCREEN_H_RESET);

   rect_type pending_rects[$];
   clip_type expected_clips[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  stim_done   = 1'b0;
   bit  hold_sender = 1'b0;   // sender pause, set by the stimulus process
   bit  calm        = 1'b0;   // no idling on either side while set

   // trim share: size*margin/whole, zero when any operand is not positive
   function automatic longint trim_share(longint size, longint margin, longint whole);
      if (whole <= 0 || margin <= 0 || size <= 0) return 0;
      return (size * margin) / whole;
   endfunction

   function automatic clip_type clip_rect(rect_type r);
      clip_type c;
      longint sx, sy, sw, sh, dx, dy, dw, dh, off, m;
      sx = r.sx; sy = r.sy; sw = r.sw; sh = r.sh;
      dx = $signed(r.dx); dy = $signed(r.dy); dw = r.dw; dh = r.dh;
      c.vis = 1'b1;
      if (dx < -dw || dy < -dh || dx > scr_w || dy > scr_h) begin
         c.vis = 1'b0;
      end else begin
         if (dx < 0) begin
            off = trim_share(r.sw, -dx, r.dw) & ~64'sd1;
            sx += off; sw -= off; dw += dx; dx = 0;
         end
         if (dy < 0) begin
            off = trim_share(r.sh, -dy, r.dh);
            sy += off; sh -= off; dh += dy; dy = 0;
         end
         if (dx + dw > scr_w) begin
            m = dx + dw - scr_w;
            dw -= m; sw -= trim_share(r.sw, m, r.dw);
         end
         if (dy + dh > scr_h) begin
            m = dy + dh - scr_h;
            dh -= m; sh -= trim_share(r.sh, m, r.dh);
         end
      end
      c.sx = sx[15:0]; c.sy = sy[15:0]; c.sw = sw[15:0]; c.sh = sh[15:0];
      c.dx = dx[15:0]; c.dy = dy[15:0]; c.dw = dw[15:0]; c.dh = dh[15:0];
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // driver: pops a word from the queue, holds it until accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_clips.push_back(clip_rect(pending_rects.pop_front()));
         end
         if (!(req_valid && !req_ready)) begin
            if (pending_rects.size() > 0 && !hold_sender
                && (calm || $urandom_range(99) >= 35)) begin
               req_valid         <= 1'b1;
               req_source_x      <= pending_rects[0].sx;
               req_source_y      <= pending_rects[0].sy;
               req_source_width  <= pending_rects[0].sw;
               req_source_height <= pending_rects[0].sh;
               req_dest_x        <= pending_rects[0].dx;
               req_dest_y        <= pending_rects[0].dy;
               req_dest_width    <= pending_rects[0].dw;
               req_dest_height   <= pending_rects[0].dh;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each accepted result with the oldest prediction
   always @(posedge clock) begin
      clip_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_clips.size() == 0) begin
               $display("unexpected result word at cycle %0d", cycle_count);
               error_count++;
            end else begin
               w = expected_clips.pop_front();
               if (rsp_visible !== w.vis)
                  report_mismatch("visible", 16'(rsp_visible), 16'(w.vis));
               if (rsp_clipped_source_x !== w.sx)
                  report_mismatch("source_x", rsp_clipped_source_x, w.sx);
               if (rsp_clipped_source_y !== w.sy)
                  report_mismatch("source_y", rsp_clipped_source_y, w.sy);
               if (rsp_clipped_source_width !== w.sw)
                  report_mismatch("source_width", rsp_clipped_source_width, w.sw);
               if (rsp_clipped_source_height !== w.sh)
                  report_mismatch("source_height", rsp_clipped_source_height, w.sh);
               if (rsp_clipped_dest_x !== w.dx)
                  report_mismatch("dest_x", rsp_clipped_dest_x, w.dx);
               if (rsp_clipped_dest_y !== w.dy)
                  report_mismatch("dest_y", rsp_clipped_dest_y, w.dy);
               if (rsp_clipped_dest_width !== w.dw)
                  report_mismatch("dest_width", rsp_clipped_dest_width, w.dw);
               if (rsp_clipped_dest_height !== w.dh)
                  report_mismatch("dest_height", rsp_clipped_dest_height, w.dh);
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 35);
      end
   end

   // one APB write: setup cycle, then access cycle until pready
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * int'(idx)); csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx == REG_SCREEN_WIDTH) scr_w = longint'(value & 32'h7fff);
      else scr_h = longint'(value & 32'h7fff);
   endtask

   // waits until every queued word went in and every result came back
   task automatic wait_drained();
      while (pending_rects.size() != 0 || req_valid || expected_clips.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic rect_type make_rect(int sx, int sy, int sw, int sh,
                                          int dx, int dy, int dw, int dh);
      rect_type r;
      r.sx = SIZE_W'(sx); r.sy = SIZE_W'(sy); r.sw = SIZE_W'(sw); r.sh = SIZE_W'(sh);
      r.dx = POS_W'(dx); r.dy = POS_W'(dy); r.dw = SIZE_W'(dw); r.dh = SIZE_W'(dh);
      return r;
   endfunction

   // random rectangle; mostly near the screen so the clips get exercised
   function automatic rect_type rand_rect();
      rect_type r;
      int mode;
      mode = int'($urandom_range(9));
      r.sx = SIZE_W'($urandom); r.sy = SIZE_W'($urandom);
      r.sw = SIZE_W'($urandom_range(32767, 1)); r.sh = SIZE_W'($urandom_range(32767, 1));
      if (mode < 7) begin
         r.dw = SIZE_W'($urandom_range(32'(2 * scr_w + 2), 1));
         r.dh = SIZE_W'($urandom_range(32'(2 * scr_h + 2), 1));
         r.dx = POS_W'(int'($urandom_range(32'(scr_w + r.dw + 2))) - int'(r.dw) - 1);
         r.dy = POS_W'(int'($urandom_range(32'(scr_h + r.dh + 2))) - int'(r.dh) - 1);
      end else begin
         r.dw = SIZE_W'($urandom_range(32767, 1)); r.dh = SIZE_W'($urandom_range(32767, 1));
         r.dx = POS_W'($urandom); r.dy = POS_W'($urandom);
      end
      return r;
   endfunction

   task automatic random_phase(int count);
      repeat (count) pending_rects.push_back(rand_rect());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, each clip edge, off screen on each side
      pending_rects.push_back(make_rect(0, 0, 1, 1, 0, 0, 1, 1));
      pending_rects.push_back(make_rect(32767, 32767, 32767, 32767, 0, 0, 32767, 32767));
      pending_rects.push_back(make_rect(100, 50, 640, 480, -100, 10, 320, 240));
      pending_rects.push_back(make_rect(100, 50, 641, 481, 10, -77, 320, 240));
      pending_rects.push_back(make_rect(0, 0, 1280, 720, 1800, 1000, 400, 300));
      pending_rects.push_back(make_rect(5, 5, 999, 777, -50, -60, 3000, 2000));
      pending_rects.push_back(make_rect(1, 2, 3, 4, -11, 0, 10, 10));
      pending_rects.push_back(make_rect(1, 2, 3, 4, 0, -11, 10, 10));
      pending_rects.push_back(make_rect(1, 2, 3, 4, -10, -10, 10, 10));
      pending_rects.push_back(make_rect(1, 2, 3, 4, 1921, 0, 10, 10));
      pending_rects.push_back(make_rect(1, 2, 3, 4, 0, 1081, 10, 10));
      pending_rects.push_back(make_rect(1, 2, 3, 4, 1920, 1080, 10, 10));
      pending_rects.push_back(make_rect(32767, 0, 32767, 9, -32768, 0, 32767, 9));
      pending_rects.push_back(make_rect(32000, 0, 32767, 9, -16000, 0, 32767, 9));
      pending_rects.push_back(make_rect(7, 7, 200, 200, 32767, 32767, 32767, 32767));
      pending_rects.push_back(make_rect(7, 7, 200, 200, -32768, -32768, 1, 1));
      random_phase(180);
      // sender holds off until the pipeline has emptied
      while (pending_rects.size() != 0 || req_valid) @(posedge clock);
      hold_sender = 1'b1;
      wait_drained();
      hold_sender = 1'b0;
      calm = 1'b1;
      random_phase(150);
      wait_drained();
      calm = 1'b0;

      csr_write(REG_SCREEN_WIDTH, 32'd1);
      csr_write(REG_SCREEN_HEIGHT, 32'd1);
      pending_rects.push_back(make_rect(3, 3, 50, 50, -2, -2, 5, 5));
      random_phase(170);
      wait_drained();

      csr_write(REG_SCREEN_WIDTH, 32'h7fff);
      csr_write(REG_SCREEN_HEIGHT, 32'h7fff);
      pending_rects.push_back(make_rect(0, 0, 32767, 32767, -1, -1, 32767, 32767));
      random_phase(170);
      wait_drained();

      // upper bits of the write data are beyond the register and ignored
      csr_write(REG_SCREEN_WIDTH, 32'hffff_8000 | 32'd800);
      csr_write(REG_SCREEN_HEIGHT, 32'd600);
      random_phase(180);
      wait_drained();

      csr_write(REG_SCREEN_WIDTH, 32'd3);
      csr_write(REG_SCREEN_HEIGHT, 32'd32000);
      random_phase(180);
      wait_drained();

      stim_done = 1'b1;
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
